[rtl/cbcs_pkg.sv]
// shared types, constants, weight table builder and saturation for the b-spline sampler
package cbcs_pkg;

	localparam int STEPS = 100;
	localparam int STEP_W = 7;
	localparam int SEG_W = 7;
	localparam int QW = 25;
	localparam int QFRAC = 24;
	localparam int PW = 60;
	localparam int SW = 62;
	localparam int RW = 38;
	localparam longint ONE_Q = 64'sd16777216;
	localparam longint DEN = 6 * STEPS * STEPS * STEPS;

	localparam logic REG_WRAP_MODE = 1'b0;
	localparam logic REG_CURVE_LENGTH = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_EVAL = 2'd1,
		OP_CLOSE = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_ZERO,
		KIND_EVAL,
		KIND_CLOSE
	} kind_t;

	typedef enum logic [1:0] {
		SHIFT_NONE,
		SHIFT_NEG,
		SHIFT_POS
	} shift_t;

	typedef logic [QW-1:0] q_t;
	typedef q_t [3:0] q4_t;
	typedef q4_t [STEPS:0] wtab_t;

	typedef struct packed {
		kind_t kind;
		logic err;
		logic [31:0] first_y;
	} meta_t;

	// basis weights in q0.24, weight 1 takes up the rounding slack
	function automatic wtab_t build_wtab();
		wtab_t tab;
		longint s;
		longint k;
		longint w0;
		longint w2;
		longint w3;
		longint q0;
		longint q2;
		longint q3;
		s = STEPS;
		for (int i = 0; i <= STEPS; i++) begin
			k = i;
			w0 = (s - k) * (s - k) * (s - k);
			w2 = -3 * k * k * k + 3 * k * k * s + 3 * k * s * s + s * s * s;
			w3 = k * k * k;
			q0 = (w0 * ONE_Q + DEN / 2) / DEN;
			q2 = (w2 * ONE_Q + DEN / 2) / DEN;
			q3 = (w3 * ONE_Q + DEN / 2) / DEN;
			tab[i][0] = QW'(q0);
			tab[i][1] = QW'(ONE_Q - q0 - q2 - q3);
			tab[i][2] = QW'(q2);
			tab[i][3] = QW'(q3);
		end
		return tab;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [RW-1:0] v);
		logic [RW-32:0] top;
		top = v[RW-1:31];
		if (top == '0 || top == '1) begin
			return v[31:0];
		end
		return v[RW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
	endfunction

endpackage

[rtl/cbcs_point_store.sv]
// point store: replicated lane memories, padded index mapping, point count
module cbcs_point_store import cbcs_pkg::*; #(
	parameter int MAX_POINTS = 64,
	localparam int AW = $clog2(MAX_POINTS),
	localparam int CW = $clog2(MAX_POINTS + 1),
	localparam int JW = ((CW > SEG_W) ? CW : SEG_W) + 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                load,
	input  logic                clear,
	input  logic                wrap_mode,
	input  logic [JW-1:0]       seg,
	input  logic [31:0]         wr_x,
	input  logic [31:0]         wr_y,
	output logic [CW-1:0]       count,
	output logic [31:0]         first_y,
	output logic [3:0][31:0]    rd_x,
	output logic [3:0][31:0]    rd_y,
	output shift_t [3:0]        rd_shift
);

	logic [CW-1:0] count_q;
	logic [31:0] first_y_q;
	logic [3:0][AW-1:0] addr;
	shift_t [3:0] sh;
	shift_t [3:0] shift_s1;

	always_comb begin
		logic [JW-1:0] n;
		logic [JW-1:0] j;
		logic [JW-1:0] src;
		n = JW'(count_q);
		for (int l = 0; l < 4; l++) begin
			j = seg + JW'(l);
			sh[l] = SHIFT_NONE;
			if (wrap_mode) begin
				// periodic ends borrow points from the other end
				if (j < JW'(2)) begin
					src = n - JW'(2) + j;
					sh[l] = SHIFT_NEG;
				end else if (j < n + JW'(2)) begin
					src = j - JW'(2);
				end else begin
					src = j - n - JW'(2);
					sh[l] = SHIFT_POS;
				end
			end else if (n == JW'(2)) begin
				src = (j < JW'(3)) ? '0 : JW'(1);
			end else if (j < JW'(2)) begin
				src = '0;
			end else if (j < n + JW'(2)) begin
				src = j - JW'(2);
			end else begin
				src = n - JW'(1);
			end
			if (src >= JW'(MAX_POINTS)) begin
				src = JW'(MAX_POINTS - 1);
			end
			addr[l] = src[AW-1:0];
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic [63:0] mem [MAX_POINTS];
		logic [63:0] data_s1;
		always_ff @(posedge clk) begin
			if (load) begin
				mem[count_q[AW-1:0]] <= {wr_y, wr_x};
			end
			if (en) begin
				data_s1 <= mem[addr[l]];
			end
		end
		assign rd_x[l] = data_s1[31:0];
		assign rd_y[l] = data_s1[63:32];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			shift_s1 <= sh;
		end
		if (load && count_q == '0) begin
			first_y_q <= wr_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign count = count_q;
	assign first_y = first_y_q;
	assign rd_shift = shift_s1;

endmodule

[rtl/cbcs_eval.sv]
// evaluation pipeline: end shift, weight products, adder tree, rounding to q16.16
module cbcs_eval import cbcs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   v_in,
	input  meta_t                  meta_in,
	input  logic [3:0][31:0]       rd_x,
	input  logic [3:0][31:0]       rd_y,
	input  shift_t [3:0]           rd_shift,
	input  q4_t                    q_in,
	input  logic [30:0]            curve_length,
	output logic                   v_out,
	output meta_t                  meta_out,
	output logic signed [RW-1:0]   rx,
	output logic signed [RW-1:0]   ry
);

	logic v_s2, v_s3, v_s4, v_s5;
	meta_t meta_s2, meta_s3, meta_s4, meta_s5;
	logic signed [32:0] px_s2 [4];
	logic signed [31:0] py_s2 [4];
	logic signed [QW:0] q_s2 [4];
	logic signed [PW-1:0] prodx_s3 [4];
	logic signed [PW-1:0] prody_s3 [4];
	logic signed [SW-1:0] sumx_s4 [2];
	logic signed [SW-1:0] sumy_s4 [2];
	logic signed [RW-1:0] rx_s5, ry_s5;
	logic signed [32:0] len33;
	logic signed [SW-1:0] totx, toty;

	assign len33 = $signed({2'b00, curve_length});
	assign totx = sumx_s4[0] + sumx_s4[1] + (SW'(1) <<< (QFRAC - 1));
	assign toty = sumy_s4[0] + sumy_s4[1] + (SW'(1) <<< (QFRAC - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_in;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2 <= meta_in;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
			for (int l = 0; l < 4; l++) begin
				unique case (rd_shift[l])
					SHIFT_NEG: px_s2[l] <= $signed({rd_x[l][31], rd_x[l]}) - len33;
					SHIFT_POS: px_s2[l] <= $signed({rd_x[l][31], rd_x[l]}) + len33;
					default:   px_s2[l] <= $signed({rd_x[l][31], rd_x[l]});
				endcase
				py_s2[l] <= $signed(rd_y[l]);
				q_s2[l] <= $signed({1'b0, q_in[l]});
				prodx_s3[l] <= px_s2[l] * q_s2[l];
				prody_s3[l] <= py_s2[l] * q_s2[l];
			end
			for (int h = 0; h < 2; h++) begin
				sumx_s4[h] <= SW'(prodx_s3[2*h]) + SW'(prodx_s3[2*h+1]);
				sumy_s4[h] <= SW'(prody_s3[2*h]) + SW'(prody_s3[2*h+1]);
			end
			// round half up: floor of (sum + half) in q0.24 units
			rx_s5 <= RW'(totx >>> QFRAC);
			ry_s5 <= RW'(toty >>> QFRAC);
		end
	end

	assign v_out = v_s5;
	assign meta_out = meta_s5;
	assign rx = rx_s5;
	assign ry = ry_s5;

endmodule

[rtl/cubic_bspline_curve_sampler.sv]
// top level: decode, weight lookup, output register with two-result closing sequence
//
// Request items enter on the s_axis channel: tuser carries the op (load point,
// evaluate sample, closing points, clear store); tdata carries point_x, point_y,
// segment and step. Result items leave on m_axis: tdata holds out_x and out_y,
// tuser the error flag and tlast marks the final result of a request.
// Configuration (wrap_mode, curve_length) is to be written through cfg_we/cfg_index/
// cfg_wdata only while no request is in flight; the block does not enforce this.
// From acceptance to the first result a request passes one memory read
// stage, shift, multiply, pair add, final add with rounding, then the fold and
// saturate into the output register. One request is accepted per cycle while
// the receiver takes results; a closing request in open mode with points stored
// gives two results and holds the input while its second result goes out. Load
// and clear take effect at acceptance, so a later request sees them with no gap.
// Reset clears the point count, the pipeline valid bits and the registers to
// wrap_mode 0 and curve_length 1.0. When the receiver stalls the whole
// pipeline holds and tready drops; nothing is lost or repeated.
module cubic_bspline_curve_sampler import cbcs_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,   // point_x[31:0], point_y[63:32], segment[70:64], step[77:71]
	input  logic [1:0]  s_axis_tuser,   // op[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // out_x[31:0], out_y[63:32]
	output logic        m_axis_tuser,   // error
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [30:0] cfg_wdata
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int JW = ((CW > SEG_W) ? CW : SEG_W) + 2;
	localparam wtab_t WTAB = build_wtab();

	logic wrap_q;
	logic [30:0] len_q;

	logic adv, accept;
	op_t op;
	logic [SEG_W-1:0] in_seg;
	logic [STEP_W-1:0] in_step, k;
	logic [CW-1:0] count, lim;
	logic [31:0] first_y;
	logic few, full;
	kind_t kind;
	logic err;
	logic [JW-1:0] seg_sel;
	logic load, clear;

	logic [3:0][31:0] rd_x, rd_y;
	shift_t [3:0] rd_shift;

	logic v_s1;
	meta_t meta_s1;
	q4_t q_s1;

	logic v_s5;
	meta_t meta_s5;
	logic signed [RW-1:0] rx_s5, ry_s5, len_ext, xf;

	logic out_v_q, pend_q, out_err_q, out_last_q;
	logic [31:0] out_x_q, out_y_q, pend_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= 1'b0;
			len_q <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WRAP_MODE:    wrap_q <= cfg_wdata[0];
				REG_CURVE_LENGTH: len_q <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	assign adv = !out_v_q || (m_axis_tready && !pend_q);
	assign s_axis_tready = adv;
	assign accept = s_axis_tvalid && adv;

	assign op = op_t'(s_axis_tuser);
	assign in_seg = s_axis_tdata[70:64];
	assign in_step = s_axis_tdata[77:71];

	always_comb begin
		// two points in open mode pad to five, so only segment 0 and 1
		lim = (count == CW'(2) && !wrap_q) ? CW'(1) : count;
		few = wrap_q ? (count < CW'(2)) : (count == '0);
		full = (count >= CW'(MAX_POINTS));
		kind = KIND_NONE;
		err = 1'b0;
		unique case (op)
			OP_LOAD: begin
				kind = KIND_ZERO;
				err = full;
			end
			OP_EVAL: begin
				if (few || JW'(in_seg) > JW'(lim)) begin
					kind = KIND_ZERO;
					err = 1'b1;
				end else begin
					kind = KIND_EVAL;
				end
			end
			OP_CLOSE: begin
				if (wrap_q) begin
					kind = KIND_NONE;
				end else if (count == '0) begin
					kind = KIND_ZERO;
					err = 1'b1;
				end else begin
					kind = KIND_CLOSE;
				end
			end
			OP_CLEAR: kind = KIND_NONE;
		endcase
		// closing evaluates the last segment at the end of its span
		seg_sel = (op == OP_CLOSE) ? JW'(lim) : JW'(in_seg);
		k = (op == OP_CLOSE || in_step > STEP_W'(STEPS)) ? STEP_W'(STEPS) : in_step;
	end

	assign load = accept && op == OP_LOAD && !full;
	assign clear = accept && op == OP_CLEAR;

	cbcs_point_store #(
		.MAX_POINTS(MAX_POINTS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.load      (load),
		.clear     (clear),
		.wrap_mode (wrap_q),
		.seg       (seg_sel),
		.wr_x      (s_axis_tdata[31:0]),
		.wr_y      (s_axis_tdata[63:32]),
		.count     (count),
		.first_y   (first_y),
		.rd_x      (rd_x),
		.rd_y      (rd_y),
		.rd_shift  (rd_shift)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= '{kind: kind, err: err, first_y: first_y};
			q_s1 <= WTAB[k];
		end
	end

	cbcs_eval u_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.v_in         (v_s1),
		.meta_in      (meta_s1),
		.rd_x         (rd_x),
		.rd_y         (rd_y),
		.rd_shift     (rd_shift),
		.q_in         (q_s1),
		.curve_length (len_q),
		.v_out        (v_s5),
		.meta_out     (meta_s5),
		.rx           (rx_s5),
		.ry           (ry_s5)
	);

	// fold x into the curve span
	always_comb begin
		len_ext = $signed({{(RW - 31){1'b0}}, len_q});
		if (rx_s5 > len_ext) begin
			xf = rx_s5 - len_ext;
		end else if (rx_s5 < 0) begin
			xf = rx_s5 + len_ext;
		end else begin
			xf = rx_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (out_v_q && m_axis_tready && pend_q) begin
			pend_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s5 && meta_s5.kind != KIND_NONE;
			pend_q <= v_s5 && meta_s5.kind == KIND_CLOSE;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && m_axis_tready && pend_q) begin
			// second closing item: start of the curve
			out_x_q <= '0;
			out_y_q <= pend_y_q;
			out_err_q <= 1'b0;
			out_last_q <= 1'b1;
		end else if (adv) begin
			pend_y_q <= meta_s5.first_y;
			unique case (meta_s5.kind)
				KIND_EVAL: begin
					out_x_q <= sat32(xf);
					out_y_q <= sat32(ry_s5);
					out_err_q <= 1'b0;
					out_last_q <= 1'b1;
				end
				KIND_CLOSE: begin
					out_x_q <= {1'b0, len_q};
					out_y_q <= sat32(ry_s5);
					out_err_q <= 1'b0;
					out_last_q <= 1'b0;
				end
				default: begin
					out_x_q <= '0;
					out_y_q <= '0;
					out_err_q <= meta_s5.err;
					out_last_q <= 1'b1;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {out_y_q, out_x_q};
	assign m_axis_tuser = out_err_q;
	assign m_axis_tlast = out_last_q;

	a_pend_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_v_q)
		else $error("closing second item pending without a valid output");

	a_pend_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !s_axis_tready)
		else $error("input accepted while closing second item pending");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(MAX_POINTS))
		else $error("point count beyond store depth");

	a_close_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(m_axis_tvalid && m_axis_tlast && !m_axis_tuser))
		else $error("first closing item not followed by its final item");

endmodule
